[hdl/tfn_pkg.sv]
package tfn_pkg;

   // Input coordinates and output components
   localparam int COORD_W = 16;
   localparam int NORM_W  = 16;

   // Exact widths through the datapath
   localparam int EDGE_W  = COORD_W + 1;     // a - b, b - c
   localparam int PROD_W  = 2 * EDGE_W;      // edge products
   localparam int CROSS_W = PROD_W + 1;      // cross product component
   localparam int MAG_W   = 33;              // |cross| < 2^33
   localparam int SQ_W    = 2 * MAG_W;       // component squared
   localparam int SUM_W   = SQ_W + 2;        // sum of three squares
   localparam int S3_W    = SUM_W + 2;       // three times the sum

   // Rounded quotient search: q in 0..2^14, one bit per step
   localparam int Q_W          = 15;
   localparam int SEARCH_STEPS = Q_W;
   localparam int RHS_SHIFT    = 2 * (Q_W - 1) + 2;   // u^2 scaled by 2^30
   localparam int RES_W        = 102;                 // signed residual width

   localparam int LANES = 3;

   typedef struct packed {
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] az;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by_;
      logic signed [COORD_W-1:0] bz;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] cz;
   } tfn_req_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] normal_x;
      logic signed [NORM_W-1:0] normal_y;
      logic signed [NORM_W-1:0] normal_z;
      logic                     degenerate;
   } tfn_rsp_type;

endpackage

[hdl/triangle_face_normal_top.sv]
// Throughput: one triangle per cycle while no response is held by rsp_stall; 6 front
// stages (edges, products, cross, magnitude, square, sum), one setup stage,
// 15 quotient-bit stages, output register.
// The whole pipeline freezes while a response is held by rsp_stall.
// Reset (synchronous, active high) clears all valid bits; payload is not reset.
module triangle_face_normal_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tfn_pkg::tfn_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tfn_pkg::tfn_rsp_type rsp_data
);
   import tfn_pkg::*;

   logic advance;

   // Stage valid bits
   logic v_edge_ff, v_prod_ff, v_cross_ff, v_mag_ff, v_sq_ff, v_sum_ff;
   logic srch_v_ff [SEARCH_STEPS+1];
   logic rsp_valid_ff;
   tfn_rsp_type rsp_data_ff, rsp_data_in;

   // Datapath registers
   logic signed [EDGE_W-1:0]  e1_ff [LANES], e1_in [LANES];
   logic signed [EDGE_W-1:0]  e2_ff [LANES], e2_in [LANES];
   logic signed [PROD_W-1:0]  pl_ff [LANES], pl_in [LANES];
   logic signed [PROD_W-1:0]  pr_ff [LANES], pr_in [LANES];
   logic signed [CROSS_W-1:0] n_ff  [LANES], n_in  [LANES];
   logic [MAG_W-1:0]          u_ff  [LANES], u_in  [LANES];
   logic [SQ_W-1:0]           sq_ff [LANES], sq_in [LANES];
   logic [SQ_W-1:0]           sq2_ff[LANES];
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic                      neg_mag_ff [LANES];
   logic                      neg_sq_ff  [LANES];
   logic                      neg_sum_ff [LANES];

   // Search pipeline: index j feeds step j
   logic signed [RES_W-1:0] r_ff  [SEARCH_STEPS][LANES];
   logic signed [RES_W-1:0] t_ff  [SEARCH_STEPS][LANES];
   logic [SUM_W-1:0]        s_ff  [SEARCH_STEPS];
   logic [S3_W-1:0]         s3_ff [SEARCH_STEPS];
   logic [Q_W-1:0]          q_ff  [SEARCH_STEPS+1][LANES];
   logic                    neg_ff[SEARCH_STEPS+1][LANES];
   logic                    degen_ff [SEARCH_STEPS+1];

   // Global enable: everything moves unless a held response blocks the output
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Edges: e1 = a - b, e2 = b - c
   always_comb begin
      e1_in[0] = $signed({req_data.ax[COORD_W-1], req_data.ax})
               - $signed({req_data.bx[COORD_W-1], req_data.bx});
      e1_in[1] = $signed({req_data.ay[COORD_W-1], req_data.ay})
               - $signed({req_data.by_[COORD_W-1], req_data.by_});
      e1_in[2] = $signed({req_data.az[COORD_W-1], req_data.az})
               - $signed({req_data.bz[COORD_W-1], req_data.bz});
      e2_in[0] = $signed({req_data.bx[COORD_W-1], req_data.bx})
               - $signed({req_data.cx[COORD_W-1], req_data.cx});
      e2_in[1] = $signed({req_data.by_[COORD_W-1], req_data.by_})
               - $signed({req_data.cy[COORD_W-1], req_data.cy});
      e2_in[2] = $signed({req_data.bz[COORD_W-1], req_data.bz})
               - $signed({req_data.cz[COORD_W-1], req_data.cz});
   end

   // Front-end valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v_edge_ff  <= 1'b0;
         v_prod_ff  <= 1'b0;
         v_cross_ff <= 1'b0;
         v_mag_ff   <= 1'b0;
         v_sq_ff    <= 1'b0;
         v_sum_ff   <= 1'b0;
      end else if (advance) begin
         v_edge_ff  <= req_valid;
         v_prod_ff  <= v_edge_ff;
         v_cross_ff <= v_prod_ff;
         v_mag_ff   <= v_cross_ff;
         v_sq_ff    <= v_mag_ff;
         v_sum_ff   <= v_sq_ff;
      end
   end

   // Per-lane front end: products, cross component, magnitude, square
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      localparam int I1 = (i + 1) % LANES;
      localparam int I2 = (i + 2) % LANES;

      logic signed [CROSS_W-1:0] n_abs;

      assign pl_in[i] = e1_ff[I1] * e2_ff[I2];
      assign pr_in[i] = e1_ff[I2] * e2_ff[I1];
      assign n_in[i]  = $signed({pl_ff[i][PROD_W-1], pl_ff[i]})
                      - $signed({pr_ff[i][PROD_W-1], pr_ff[i]});
      assign n_abs    = n_ff[i][CROSS_W-1] ? -n_ff[i] : n_ff[i];
      assign u_in[i]  = n_abs[MAG_W-1:0];
      assign sq_in[i] = u_ff[i] * u_ff[i];

      always_ff @(posedge clock) begin
         if (advance) begin
            e1_ff[i]      <= e1_in[i];
            e2_ff[i]      <= e2_in[i];
            pl_ff[i]      <= pl_in[i];
            pr_ff[i]      <= pr_in[i];
            n_ff[i]       <= n_in[i];
            u_ff[i]       <= u_in[i];
            neg_mag_ff[i] <= n_ff[i][CROSS_W-1];
            sq_ff[i]      <= sq_in[i];
            neg_sq_ff[i]  <= neg_mag_ff[i];
            sq2_ff[i]     <= sq_ff[i];
            neg_sum_ff[i] <= neg_sq_ff[i];
         end
      end
   end

   // Squared length
   assign sum_in = {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff <= sum_in;
      end
   end

   // Search setup: p = -1, residual R = 2^30 u^2 - s, trial T = 2^30 s - 2^16 s
   logic signed [RES_W-1:0] s_ext;

   assign s_ext = $signed({{(RES_W-SUM_W){1'b0}}, sum_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         srch_v_ff[0] <= 1'b0;
      end else if (advance) begin
         srch_v_ff[0] <= v_sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s_ff[0]     <= sum_ff;
         s3_ff[0]    <= {2'b00, sum_ff} + {1'b0, sum_ff, 1'b0};
         degen_ff[0] <= (sum_ff == '0);
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_init
      logic signed [RES_W-1:0] rhs;

      assign rhs = $signed({{(RES_W-SQ_W-RHS_SHIFT){1'b0}}, sq2_ff[i], {RHS_SHIFT{1'b0}}});

      always_ff @(posedge clock) begin
         if (advance) begin
            r_ff[0][i]   <= rhs - s_ext;
            t_ff[0][i]   <= (s_ext <<< RHS_SHIFT) - (s_ext <<< (Q_W + 1));
            q_ff[0][i]   <= '0;
            neg_ff[0][i] <= neg_sum_ff[i];
         end
      end
   end

   // One quotient bit per stage, from bit 14 down to bit 0.
   // Trial q' = q + 2^k is kept when 2^30 u^2 - (2q'-1)^2 s >= 0.
   for (genvar j = 0; j < SEARCH_STEPS; j++) begin : g_step
      localparam int K = SEARCH_STEPS - 1 - j;

      always_ff @(posedge clock) begin
         if (reset) begin
            srch_v_ff[j+1] <= 1'b0;
         end else if (advance) begin
            srch_v_ff[j+1] <= srch_v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            degen_ff[j+1] <= degen_ff[j];
         end
      end

      if (j + 1 < SEARCH_STEPS) begin : g_pass
         always_ff @(posedge clock) begin
            if (advance) begin
               s_ff[j+1]  <= s_ff[j];
               s3_ff[j+1] <= s3_ff[j];
            end
         end
      end

      for (genvar i = 0; i < LANES; i++) begin : g_lane
         logic signed [RES_W-1:0] diff;
         logic                    keep;
         logic [Q_W-1:0]          q_in;

         assign diff = r_ff[j][i] - t_ff[j][i];
         assign keep = !diff[RES_W-1];

         always_comb begin
            q_in    = q_ff[j][i];
            q_in[K] = keep;
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               q_ff[j+1][i]   <= q_in;
               neg_ff[j+1][i] <= neg_ff[j][i];
            end
         end

         // Residual and next trial step only needed while bits remain
         if (j + 1 < SEARCH_STEPS) begin : g_upd
            logic signed [RES_W-1:0] t_half, s_sh, s3_sh, r_in, t_in;

            assign t_half = t_ff[j][i] >>> 1;
            assign s_sh   = $signed({{(RES_W-SUM_W){1'b0}}, s_ff[j]}) <<< (2 * K);
            assign s3_sh  = $signed({{(RES_W-S3_W){1'b0}}, s3_ff[j]}) <<< (2 * K);
            assign r_in   = keep ? diff : r_ff[j][i];
            assign t_in   = keep ? (t_half + s3_sh) : (t_half - s_sh);

            always_ff @(posedge clock) begin
               if (advance) begin
                  r_ff[j+1][i] <= r_in;
                  t_ff[j+1][i] <= t_in;
               end
            end
         end
      end
   end

   // Sign and degenerate override
   logic signed [NORM_W-1:0] comp [LANES];

   for (genvar i = 0; i < LANES; i++) begin : g_out
      logic signed [NORM_W-1:0] q_s;

      assign q_s     = $signed({{(NORM_W-Q_W){1'b0}}, q_ff[SEARCH_STEPS][i]});
      assign comp[i] = degen_ff[SEARCH_STEPS] ? '0
                     : (neg_ff[SEARCH_STEPS][i] ? -q_s : q_s);
   end

   always_comb begin
      rsp_data_in.normal_x   = comp[0];
      rsp_data_in.normal_y   = comp[1];
      rsp_data_in.normal_z   = comp[2];
      rsp_data_in.degenerate = degen_ff[SEARCH_STEPS];
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= srch_v_ff[SEARCH_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

[hdl/tfn_checker.sv]
module tfn_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input tfn_pkg::tfn_rsp_type rsp_data
);
   import tfn_pkg::*;

   // A held response transaction stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Back-pressure reaches the input exactly when the output is blocked
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall does not follow blocked response");

   // Degenerate triangle gives a zero normal
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.normal_x == '0 && rsp_data.normal_y == '0 && rsp_data.normal_z == '0)
      else $error("degenerate response with nonzero normal");

   // A proper normal has a nonzero component, all within unit range
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.degenerate |->
         (rsp_data.normal_x != '0 || rsp_data.normal_y != '0 || rsp_data.normal_z != '0)
         && $signed(rsp_data.normal_x) >= -16384 && $signed(rsp_data.normal_x) <= 16384
         && $signed(rsp_data.normal_y) >= -16384 && $signed(rsp_data.normal_y) <= 16384
         && $signed(rsp_data.normal_z) >= -16384 && $signed(rsp_data.normal_z) <= 16384)
      else $error("normal out of range");

   // No response in the cycle after a reset cycle
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind triangle_face_normal_top tfn_checker u_tfn_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[dv/tb_top.sv]
module tb_top;
   import tfn_pkg::*;

   localparam int RANDOM_ITEMS = 1900;
   localparam int SETTLE_CYCLES = 40;      // past the pipeline latency
   localparam int RESET_CYCLES = 7;
   localparam int MODE_SPAN = 256;         // cycles per receiver stall mode

   // Receiver stall modes
   localparam int STALL_NONE = 0;
   localparam int STALL_LIGHT = 1;
   localparam int STALL_HEAVY = 2;
   localparam int STALL_PERIODIC = 3;

   // Random triangle shapes
   localparam int SHAPE_ANY = 0;
   localparam int SHAPE_LOCAL = 1;
   localparam int SHAPE_COLLINEAR = 2;
   localparam int SHAPE_AXIS_PLANE = 3;
   localparam int SHAPE_EXTREME = 4;

   // Holds the expected normals in order and checks each response against them
   class normal_scoreboard;
      tfn_rsp_type pending_normals[$];
      int unsigned failures;

      function new();
         failures = 0;
      endfunction

      // Exact unit normal: components of the cross product scaled to 2^14,
      // rounded to nearest with ties away from zero
      function tfn_rsp_type face_normal(tfn_req_type c);
         longint e1[3];
         longint e2[3];
         longint n[3];
         logic [127:0] u[3];
         logic [127:0] s;
         logic [127:0] rhs;
         logic [127:0] t;
         logic signed [NORM_W-1:0] comp[3];
         int lo;
         int hi;
         int q;
         tfn_rsp_type r;
         e1[0] = longint'(c.ax) - longint'(c.bx);
         e1[1] = longint'(c.ay) - longint'(c.by_);
         e1[2] = longint'(c.az) - longint'(c.bz);
         e2[0] = longint'(c.bx) - longint'(c.cx);
         e2[1] = longint'(c.by_) - longint'(c.cy);
         e2[2] = longint'(c.bz) - longint'(c.cz);
         n[0] = e1[1] * e2[2] - e1[2] * e2[1];
         n[1] = e1[2] * e2[0] - e1[0] * e2[2];
         n[2] = e1[0] * e2[1] - e1[1] * e2[0];
         s = '0;
         for (int i = 0; i < LANES; i++) begin
            u[i] = 128'((n[i] < 0) ? -n[i] : n[i]);
            s = s + u[i] * u[i];
         end
         r = '0;
         // zero-length cross product: zero normal, flag set
         if (s == 0) begin
            r.degenerate = 1'b1;
            return r;
         end
         // largest q with (2q-1)^2 * |n|^2 <= u^2 * 2^30
         for (int i = 0; i < LANES; i++) begin
            lo = 0;
            hi = 1 << (Q_W - 1);
            rhs = (u[i] * u[i]) << RHS_SHIFT;
            while (lo < hi) begin
               q = (lo + hi + 1) / 2;
               t = 128'((2 * q - 1) * (2 * q - 1));
               if (s * t <= rhs) lo = q;
               else hi = q - 1;
            end
            comp[i] = NORM_W'((n[i] < 0) ? -lo : lo);
         end
         r.normal_x = comp[0];
         r.normal_y = comp[1];
         r.normal_z = comp[2];
         return r;
      endfunction

      function void note_triangle(tfn_req_type c);
         pending_normals = {pending_normals, face_normal(c)};
      endfunction

      function void compare_field(string field, logic signed [NORM_W-1:0] want,
                                  logic signed [NORM_W-1:0] got);
         if (got !== want) begin
            failures++;
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
         end
      endfunction

      function void check_normal(tfn_rsp_type got);
         tfn_rsp_type want;
         if (pending_normals.size() == 0) begin
            failures++;
            $display("%0t: response expected none got normal (%0d,%0d,%0d) degenerate %0b",
                     $time, got.normal_x, got.normal_y, got.normal_z, got.degenerate);
            return;
         end
         want = pending_normals.pop_front();
         compare_field("normal_x", want.normal_x, got.normal_x);
         compare_field("normal_y", want.normal_y, got.normal_y);
         compare_field("normal_z", want.normal_z, got.normal_z);
         compare_field("degenerate", NORM_W'(want.degenerate), NORM_W'(got.degenerate));
      endfunction

      function int pending();
         return pending_normals.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   tfn_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   tfn_rsp_type rsp_data;

   int unsigned rsp_cycle = 0;
   int unsigned rsp_mode = STALL_NONE;

   normal_scoreboard expected_normals = new();

   triangle_face_normal_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver stall pattern: each mode sets how rsp_stall is driven; the mode is redrawn at random
   always @(posedge clock) begin
      rsp_cycle <= rsp_cycle + 1;
      if (rsp_cycle % MODE_SPAN == 0) rsp_mode <= $urandom_range(STALL_NONE, STALL_PERIODIC);
      case (rsp_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
         default: rsp_stall <= ((rsp_cycle % 7) < 3);
      endcase
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) expected_normals.check_normal(rsp_data);
   end

   function automatic tfn_req_type make_tri(
         logic signed [COORD_W-1:0] ax, logic signed [COORD_W-1:0] ay,
         logic signed [COORD_W-1:0] az, logic signed [COORD_W-1:0] bx,
         logic signed [COORD_W-1:0] by_, logic signed [COORD_W-1:0] bz,
         logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy,
         logic signed [COORD_W-1:0] cz);
      tfn_req_type t;
      t.ax = ax;
      t.ay = ay;
      t.az = az;
      t.bx = bx;
      t.by_ = by_;
      t.bz = bz;
      t.cx = cx;
      t.cy = cy;
      t.cz = cz;
      return t;
   endfunction

   function automatic logic signed [COORD_W-1:0] extreme_coord();
      case ($urandom_range(0, 6))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh8001;
         3: return 16'sh7FFE;
         4: return -16'sd1;
         5: return 16'sd1;
         default: return 16'sd0;
      endcase
   endfunction

   function automatic logic signed [COORD_W-1:0] small_step();
      return COORD_W'($signed($urandom_range(0, 16)) - 8);
   endfunction

   function automatic tfn_req_type extreme_tri();
      return make_tri(extreme_coord(), extreme_coord(), extreme_coord(),
                      extreme_coord(), extreme_coord(), extreme_coord(),
                      extreme_coord(), extreme_coord(), extreme_coord());
   endfunction

   function automatic tfn_req_type random_triangle();
      tfn_req_type t;
      logic [159:0] raw;
      logic signed [COORD_W-1:0] dx;
      logic signed [COORD_W-1:0] dy;
      logic signed [COORD_W-1:0] dz;
      int unsigned roll;
      int shape;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      t = tfn_req_type'(raw[$bits(tfn_req_type)-1:0]);
      roll = $urandom_range(0, 99);
      if (roll < 50) shape = SHAPE_ANY;
      else if (roll < 65) shape = SHAPE_LOCAL;
      else if (roll < 75) shape = SHAPE_COLLINEAR;
      else if (roll < 87) shape = SHAPE_AXIS_PLANE;
      else shape = SHAPE_EXTREME;
      case (shape)
         // small triangle around a random point
         SHAPE_LOCAL: begin
            t.bx = t.ax + small_step();
            t.by_ = t.ay + small_step();
            t.bz = t.az + small_step();
            t.cx = t.ax + small_step();
            t.cy = t.ay + small_step();
            t.cz = t.az + small_step();
         end
         // corners on one line (equal corners when the step is zero)
         SHAPE_COLLINEAR: begin
            dx = small_step();
            dy = small_step();
            dz = small_step();
            t.bx = t.ax + dx;
            t.by_ = t.ay + dy;
            t.bz = t.az + dz;
            t.cx = t.ax + (dx <<< 1);
            t.cy = t.ay + (dy <<< 1);
            t.cz = t.az + (dz <<< 1);
         end
         // triangle in a plane normal to one axis
         SHAPE_AXIS_PLANE: begin
            case ($urandom_range(0, 2))
               0: begin
                  t.bx = t.ax;
                  t.cx = t.ax;
               end
               1: begin
                  t.by_ = t.ay;
                  t.cy = t.ay;
               end
               default: begin
                  t.bz = t.az;
                  t.cz = t.az;
               end
            endcase
         end
         SHAPE_EXTREME: t = extreme_tri();
         default: ;
      endcase
      return t;
   endfunction

   // Present one triangle and hold it until accepted
   task automatic send_triangle(input tfn_req_type corners);
      req_data <= corners;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_normals.note_triangle(corners);
   endtask

   task automatic idle_cycles(input int count);
      req_valid <= 1'b0;
      repeat (count) @(posedge clock);
   endtask

   // Hold off until every outstanding normal has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_normals.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int sent;
      int burst;
      int gap_roll;
      bit paused;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: degenerate cases, axis normals, diagonals, range extremes
      send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_triangle(make_tri(16'sh1234, -16'sd77, 16'sh4000,
                             16'sh1234, -16'sd77, 16'sh4000,
                             16'sh1234, -16'sd77, 16'sh4000));
      send_triangle(make_tri(0, 0, 0, 256, 512, 768, 512, 1024, 1536));
      send_triangle(make_tri(0, 0, 0, 256, 0, 0, 256, 256, 0));
      send_triangle(make_tri(256, 256, 0, 256, 0, 0, 0, 0, 0));
      send_triangle(make_tri(0, 0, 0, 0, 256, 0, 0, 256, 256));
      send_triangle(make_tri(0, 0, 0, 0, 0, 256, 256, 0, 256));
      send_triangle(make_tri(256, 0, 0, 0, 256, 0, 0, 0, 256));
      send_triangle(make_tri(0, 0, 0, 256, 0, 0, 256, 256, 256));
      send_triangle(make_tri(0, 0, 0, 1, 0, 0, 1, 1, 0));
      send_triangle(make_tri(16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                             16'sh8000, 16'sh8000, 16'sh8000,
                             16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
      send_triangle(make_tri(16'sh7FFF, 16'sh8000, 0,
                             16'sh8000, 16'sh7FFF, 16'sh8000,
                             16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
      send_triangle(make_tri(16'sh8000, 16'sh8000, 16'sh8000,
                             16'sh7FFF, 16'sh8000, 16'sh7FFF,
                             16'sh8000, 16'sh7FFF, 16'sh7FFF));
      send_triangle(make_tri(16'sh8000, 0, 0, 16'sh7FFF, 0, 0, 16'sh7FFF, 1, 0));
      repeat (8) send_triangle(extreme_tri());
      wait_for_drain();

      // Random: bursts with gaps, one full drain halfway
      sent = 0;
      paused = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 48);
         repeat (burst) begin
            send_triangle(random_triangle());
            sent++;
         end
         gap_roll = $urandom_range(0, 9);
         if (!paused && sent >= RANDOM_ITEMS / 2) begin
            wait_for_drain();
            paused = 1'b1;
         end else if (gap_roll >= 9) begin
            idle_cycles($urandom_range(10, 30));
         end else if (gap_roll >= 3) begin
            idle_cycles($urandom_range(1, 6));
         end
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_normals.failures == 0 && expected_normals.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Run limit
   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
